>>> src/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants, command and result codes and the burst descriptor for
// the sliding window sender.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int WINDOW        = 8;
  localparam int CHUNK_PACKETS = 512;

  // Base counter holds 0 .. CHUNK_PACKETS-1.
  localparam int BASE_W = $clog2(CHUNK_PACKETS + 1);
  localparam int SLOT_W = $clog2(WINDOW + 1);
  localparam int CMD_W  = 2;
  localparam int SEQ_W  = 16;

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // One input's worth of results: a set of window slots to send from a base,
  // or a single done result.
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [WINDOW-1:0] mask;
    logic              done;
  } burst_t;

endpackage

>>> src/sws_emitter.sv
// ----------------------------------------------------------------------------
// sws_emitter
// Result register: holds one burst and hands out its results one transfer
// per cycle while out_ready is high, lowest window slot first.
// ----------------------------------------------------------------------------
module sws_emitter
  import sws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  burst_t           load_burst,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [SEQ_W-1:0] out_seq_number,
  output logic             out_last
);

  logic              vld_r, vld_nxt;
  burst_t            burst_r, burst_nxt;
  logic [WINDOW-1:0] rest;
  logic [WINDOW-1:0] low_bit;
  logic [SLOT_W-1:0] slot;
  logic              last_now;
  logic              fire;

  assign rest     = burst_r.mask & (burst_r.mask - WINDOW'(1));
  assign low_bit  = burst_r.mask & ~rest;
  assign last_now = burst_r.done || (rest == '0);
  assign fire     = vld_r && out_ready;
  assign free     = !vld_r || (fire && last_now);

  always_comb begin
    slot = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (low_bit[j]) begin
        slot = SLOT_W'(j);
      end
    end
  end

  assign out_valid      = vld_r;
  assign out_kind       = burst_r.done ? KIND_DONE : KIND_SEND;
  assign out_seq_number = burst_r.done ? '0
                        : SEQ_W'(burst_r.base) + SEQ_W'(slot) + SEQ_W'(1);
  assign out_last       = last_now;

  always_comb begin
    vld_nxt   = vld_r;
    burst_nxt = burst_r;
    if (load) begin
      vld_nxt   = 1'b1;
      burst_nxt = load_burst;
    end else if (fire) begin
      burst_nxt.mask = rest;
      if (last_now) begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    burst_r <= burst_nxt;
  end

endmodule

>>> src/sliding_window_sender.sv
// ----------------------------------------------------------------------------
// sliding_window_sender
// Sender side of a cumulative-ack sliding window for one chunk transfer.
// ----------------------------------------------------------------------------
// Each command is registered; the window state is updated and the set of
// packets to send is loaded into the result register in the same cycle, once
// that register is free. The result register then delivers one result per
// cycle while out_ready is high. A command thus occupies the result side
// until all its results are out (up to WINDOW; a done result stands alone);
// commands with no result pass without waiting for the result register.
// A new command is taken every cycle that the result register is free or is
// handing out its final result, so back-to-back windows stream without gaps.
// Sequence numbers are one-based; the done result carries sequence zero and
// the block then goes idle until the next start.
module sliding_window_sender
  import sws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [SEQ_W-1:0] in_ack_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [SEQ_W-1:0] out_seq_number,
  output logic             out_last
);

  logic              in_vld_r;
  logic [CMD_W-1:0]  in_cmd_r;
  logic [SEQ_W-1:0]  in_ack_r;

  logic [BASE_W-1:0] base_r, base_nxt;
  logic [WINDOW-1:0] marks_r, marks_nxt;
  logic              active_r, active_nxt;

  logic [WINDOW-1:0] marks_tmp;
  logic [WINDOW-1:0] range_mask;
  logic [WINDOW-1:0] emit;
  logic              emit_en;
  logic              only_unsent;
  logic              done;
  logic [SEQ_W-1:0]  step;
  logic              has_results;
  logic              em_free;
  logic              advance;
  logic              load;
  burst_t            load_burst;

  assign step = in_ack_r - SEQ_W'(base_r);

  always_comb begin
    base_nxt    = base_r;
    marks_tmp   = marks_r;
    active_nxt  = active_r;
    emit_en     = 1'b0;
    only_unsent = 1'b1;
    done        = 1'b0;
    unique case (in_cmd_r)
      CMD_START: begin
        base_nxt   = '0;
        marks_tmp  = '0;
        active_nxt = 1'b1;
        emit_en    = 1'b1;
      end
      CMD_ACK: begin
        if (active_r && (in_ack_r > SEQ_W'(base_r))) begin
          if (in_ack_r >= SEQ_W'(CHUNK_PACKETS)) begin
            base_nxt   = '0;
            marks_tmp  = '0;
            active_nxt = 1'b0;
            done       = 1'b1;
          end else begin
            base_nxt  = BASE_W'(in_ack_r);
            // A shift of WINDOW or more leaves no mark.
            marks_tmp = marks_r >> step;
            emit_en   = 1'b1;
          end
        end
      end
      CMD_TIMEOUT: begin
        if (active_r) begin
          emit_en     = 1'b1;
          only_unsent = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      range_mask[j] = (32'(base_nxt) + 32'(j)) < 32'(CHUNK_PACKETS);
    end
  end

  assign emit        = !emit_en ? '0
                     : (only_unsent ? (range_mask & ~marks_tmp) : range_mask);
  assign marks_nxt   = marks_tmp | emit;
  assign has_results = done || (emit != '0);

  assign advance  = in_vld_r && (!has_results || em_free);
  assign load     = in_vld_r && has_results && em_free;
  assign in_ready = !in_vld_r || advance;

  assign load_burst.base = base_nxt;
  assign load_burst.mask = emit;
  assign load_burst.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      base_r   <= '0;
      marks_r  <= '0;
      active_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        base_r   <= base_nxt;
        marks_r  <= marks_nxt;
        active_r <= active_nxt;
      end
    end
    if (in_valid && in_ready) begin
      in_cmd_r <= in_cmd;
      in_ack_r <= in_ack_number;
    end
  end

  sws_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .load_burst     (load_burst),
    .free           (em_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_seq_number (out_seq_number),
    .out_last       (out_last)
  );

endmodule

>>> src/sws_checker.sv
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks for the sliding window sender, bound to the top level.
// ----------------------------------------------------------------------------
module sws_checker
  import sws_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_kind,
  input logic [SEQ_W-1:0] out_seq_number,
  input logic             out_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seq_number)
      && $stable(out_kind) && $stable(out_last))
    else $error("result changed while stalled");

  // The done result stands alone with sequence zero.
  a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_last && out_seq_number == '0)
    else $error("malformed done result");

  // Data packets are one-based.
  a_send_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SEND |-> out_seq_number != '0)
    else $error("send result with sequence zero");

  // Within one burst the next result follows at once with a higher number.
  a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_kind == KIND_SEND
      && out_seq_number > $past(out_seq_number))
    else $error("burst results out of order");

endmodule

bind sliding_window_sender sws_checker u_sws_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_seq_number (out_seq_number),
  .out_last       (out_last)
);

>>> test/tb_sliding_window_sender.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_sender
// Self-checking testbench for the sliding window sender. A table of directed
// commands runs first, then random chunk transfers. Every result transfer is
// checked against the results given in the table or, where none are given,
// against a window predictor kept inside the testbench, with random idle cycles and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sliding_window_sender;
  import sws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 410;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 3000;
  localparam int TAIL_CYCLES    = 24;

  typedef struct {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } window_result_t;

  // One directed command; where typed is set, the results are given here as
  // cnt consecutive sequence numbers starting at first.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] ack;
    logic             typed;
    logic [3:0]       cnt;
    logic             kind;
    logic [SEQ_W-1:0] first;
  } cmd_row_t;

  localparam int N_ROWS = 24;
  localparam cmd_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{CMD_ACK,     16'd5,     1'b1, 4'd0, KIND_SEND, 16'd0},
    '{CMD_TIMEOUT, 16'd0,     1'b1, 4'd0, KIND_SEND, 16'd0},
    '{CMD_UNUSED,  16'hFFFF,  1'b1, 4'd0, KIND_SEND, 16'd0},
    '{CMD_START,   16'h0000,  1'b1, 4'd8, KIND_SEND, 16'd1},
    '{CMD_ACK,     16'd0,     1'b1, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd3,     1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd3,     1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_TIMEOUT, 16'h5555,  1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd20,    1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_UNUSED,  16'hAAAA,  1'b1, 4'd0, KIND_SEND, 16'd0},
    '{CMD_START,   16'hFFFF,  1'b1, 4'd8, KIND_SEND, 16'd1},
    '{CMD_ACK,     16'd505,   1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_TIMEOUT, 16'd0,     1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd511,   1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd512,   1'b1, 4'd1, KIND_DONE, 16'd0},
    '{CMD_ACK,     16'd600,   1'b1, 4'd0, KIND_SEND, 16'd0},
    '{CMD_START,   16'h0000,  1'b1, 4'd8, KIND_SEND, 16'd1},
    '{CMD_ACK,     16'hFFFF,  1'b1, 4'd1, KIND_DONE, 16'd0},
    '{CMD_START,   16'h1234,  1'b1, 4'd8, KIND_SEND, 16'd1},
    '{CMD_ACK,     16'd1,     1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_TIMEOUT, 16'hAAAA,  1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd9,     1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd511,   1'b0, 4'd0, KIND_SEND, 16'd0},
    '{CMD_ACK,     16'd513,   1'b1, 4'd1, KIND_DONE, 16'd0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [SEQ_W-1:0] in_ack_number;
  logic             out_valid;
  logic             out_ready;
  logic             out_kind;
  logic [SEQ_W-1:0] out_seq_number;
  logic             out_last;

  // Predictor state.
  logic [BASE_W-1:0] win_base;
  logic [WINDOW-1:0] win_sent;
  logic              xfer_active;

  window_result_t burst_due[$];
  window_result_t packets_due[$];
  window_result_t head;

  int  errors;
  int  results_checked;
  int  chunks_done;
  int  cmds_sent;
  int  idle_cycles;
  bit  calm_run;
  bit  rx_hold_req;

  sliding_window_sender uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_ack_number  (in_ack_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_seq_number (out_seq_number),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Queue a send for every in-range window slot, skipping marked slots when
  // asked; the marks of emitted slots are set.
  function automatic int send_window(input bit skip_sent);
    int n;
    int idx;
    window_result_t r;
    n = 0;
    for (int j = 0; j < WINDOW; j++) begin
      idx = int'(win_base) + j;
      if (idx >= CHUNK_PACKETS) break;
      if (!(skip_sent && win_sent[j])) begin
        r.kind = KIND_SEND;
        r.seq  = SEQ_W'(idx + 1);
        r.last = 1'b0;
        burst_due.push_back(r);
        win_sent[j] = 1'b1;
        n++;
      end
    end
    return n;
  endfunction

  // Advance the window for one accepted command and leave its results in
  // burst_due.
  function automatic void advance_window(input logic [CMD_W-1:0] cmd,
                                         input logic [SEQ_W-1:0] ack);
    int n;
    int step;
    window_result_t r;
    n = 0;
    burst_due.delete();
    case (cmd)
      CMD_START: begin
        win_base    = '0;
        win_sent    = '0;
        xfer_active = 1'b1;
        n = send_window(1'b1);
      end
      CMD_ACK: begin
        if (xfer_active && ack > SEQ_W'(win_base)) begin
          step = int'(ack) - int'(win_base);
          if (int'(ack) >= CHUNK_PACKETS) begin
            win_base    = '0;
            win_sent    = '0;
            xfer_active = 1'b0;
            r.kind = KIND_DONE;
            r.seq  = '0;
            r.last = 1'b0;
            burst_due.push_back(r);
            n = 1;
          end else begin
            win_base = ack[BASE_W-1:0];
            if (step >= WINDOW) win_sent = '0;
            else win_sent = win_sent >> step;
            n = send_window(1'b1);
          end
        end
      end
      CMD_TIMEOUT: begin
        if (xfer_active) n = send_window(1'b0);
      end
      default: ;
    endcase
    if (n > 0) burst_due[n-1].last = 1'b1;
  endfunction

  // Offer one command, wait for its transfer, then queue what it must cause.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] ack,
                               input bit typed, input int cnt, input logic kind,
                               input logic [SEQ_W-1:0] first);
    window_result_t r;
    @(negedge clk);
    if (!calm_run && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_ack_number <= ack;
    do @(posedge clk); while (!in_ready);
    cmds_sent++;
    advance_window(cmd, ack);
    if (typed) begin
      for (int i = 0; i < cnt; i++) begin
        r.kind = kind;
        r.seq  = first + SEQ_W'(i);
        r.last = (i == cnt - 1);
        packets_due.push_back(r);
      end
    end else begin
      foreach (burst_due[i]) packets_due.push_back(burst_due[i]);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm_run || ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (packets_due.size() == 0) begin
        $error("unexpected result: kind %0d seq %0d last %0d",
               out_kind, out_seq_number, out_last);
        errors++;
      end else begin
        head = packets_due.pop_front();
        results_checked++;
        if (out_kind === KIND_DONE) chunks_done++;
        if (out_kind !== head.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", head.kind, out_kind);
          errors++;
        end
        if (out_seq_number !== head.seq) begin
          $error("seq_number mismatch: expected %0d, actual %0d", head.seq, out_seq_number);
          errors++;
        end
        if (out_last !== head.last) begin
          $error("last mismatch: expected %0d, actual %0d", head.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
      $display("** sliding_window_sender: FAILED **");
      $finish;
    end
  end

  initial begin
    int acted;
    int k;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] ack;
    bit ignored;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_START;
    in_ack_number = '0;
    win_base      = '0;
    win_sent      = '0;
    xfer_active   = 1'b0;
    errors        = 0;
    results_checked = 0;
    chunks_done   = 0;
    cmds_sent     = 0;
    idle_cycles   = 0;
    calm_run      = 1'b0;
    rx_hold_req   = 1'b0;
    acted         = 0;
    k             = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      issue_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].ack, DIRECTED_ROWS[i].typed,
                    int'(DIRECTED_ROWS[i].cnt), DIRECTED_ROWS[i].kind,
                    DIRECTED_ROWS[i].first);
    end

    // Random chunk transfers: mostly forward acks with occasional timeouts,
    // stale acks, restarts, unused commands and wild ack numbers.
    while (acted < RANDOM_ITEMS) begin
      if (k == 120) rx_hold_req = 1'b1;
      if (k == 320) begin
        // The last command is already taken, so the offer is withdrawn first.
        @(negedge clk);
        in_valid <= 1'b0;
        while (packets_due.size() != 0) @(posedge clk);
      end
      calm_run = (k >= 180 && k < 260);
      pick = $urandom_range(0, 99);
      ack  = SEQ_W'($urandom);
      if (!xfer_active) begin
        if (pick < 85)      cmd = CMD_START;
        else if (pick < 92) cmd = CMD_ACK;
        else if (pick < 96) cmd = CMD_TIMEOUT;
        else                cmd = CMD_UNUSED;
      end else if (pick < 68) begin
        cmd = CMD_ACK;
        ack = SEQ_W'(int'(win_base) + $urandom_range(1, 10));
      end else if (pick < 76) begin
        cmd = CMD_ACK;
        ack = SEQ_W'(int'(win_base) + $urandom_range(1, 600));
      end else if (pick < 85) begin
        cmd = CMD_TIMEOUT;
      end else if (pick < 91) begin
        cmd = CMD_ACK;
        ack = SEQ_W'($urandom_range(0, int'(win_base)));
      end else if (pick < 95) begin
        cmd = CMD_UNUSED;
      end else if (pick < 97) begin
        cmd = CMD_START;
      end else begin
        cmd = CMD_ACK;
      end
      ignored = (cmd == CMD_UNUSED) || (!xfer_active && cmd != CMD_START);
      issue_command(cmd, ack, 1'b0, 0, KIND_SEND, '0);
      if (!ignored) acted++;
      k++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    calm_run = 1'b0;
    while (packets_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d directed) and checked %0d results,", cmds_sent,
             N_ROWS, results_checked);
    $display("including %0d finished chunks, under random stalls and one long hold-off.",
             chunks_done);
    if (errors == 0 && packets_due.size() == 0) begin
      $display("** sliding_window_sender: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never seen.", errors, packets_due.size());
      $display("** sliding_window_sender: FAILED **");
    end
    $finish;
  end

endmodule
